@@ hw/rtl/assert_macros.svh @@
// Assertion macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Check that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, trig, cons, msg)
`endif
`endif

@@ hw/rtl/jsu_pkg.sv @@
// Types, character codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_BSL  = 3'd3,
    PH_U    = 3'd4,
    PH_HEX2 = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    ST_BYTE     = 4'd0,
    ST_DONE     = 4'd1,
    ST_UNTERM   = 4'd2,
    ST_BAD_ESC  = 4'd3,
    ST_SHORT_U  = 4'd4,
    ST_BAD_HEX  = 4'd5,
    ST_MISS_LOW = 4'd6,
    ST_EXP_U    = 4'd7,
    ST_BAD_LOW  = 4'd8,
    ST_LONE_LOW = 4'd9,
    ST_CTRL     = 4'd10
  } status_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Top six bits of the high and low surrogate ranges
  localparam logic [5:0] SUR_HIGH = 6'b110110;
  localparam logic [5:0] SUR_LOW  = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // One decoded burst of up to four results
  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
    status_e         status;
  } burst_t;

  // {ok, value} of a hex digit
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {ok, decoded byte} of a short escape letter
  function automatic logic [8:0] short_escape(logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      CH_QUOTE: r = {1'b1, CH_QUOTE};
      CH_BSL:   r = {1'b1, CH_BSL};
      CH_SLASH: r = {1'b1, CH_SLASH};
      CH_B:     r = {1'b1, CTL_BS};
      CH_F:     r = {1'b1, CTL_FF};
      CH_N:     r = {1'b1, CTL_LF};
      CH_R:     r = {1'b1, CTL_CR};
      CH_T:     r = {1'b1, CTL_HT};
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/jsu_decode.sv @@
// Escape decoder: parse state and the combinational step that forms one burst.
module jsu_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output jsu_pkg::burst_t  burst_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [11:0]     accum_q, accum_d;
  logic [1:0]      count_q, count_d;
  logic [9:0]      high_q, high_d;
  logic            err_q, err_d;

  logic [4:0]      hex;
  logic [8:0]      esc;
  logic [15:0]     hex_word;
  logic [20:0]     pair_code;
  logic [20:0]     code;
  logic            emit;
  logic            fail;
  jsu_pkg::status_e fail_st;

  assign hex       = jsu_pkg::hex_digit(byte_i);
  assign esc       = jsu_pkg::short_escape(byte_i);
  assign hex_word  = {accum_q, hex[3:0]};
  assign pair_code = jsu_pkg::SUPP_BASE + {1'b0, high_q, hex_word[9:0]};

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    count_d = count_q;
    high_d  = high_q;
    err_d   = err_q;
    burst_o = '0;
    burst_o.status = jsu_pkg::ST_BYTE;
    emit    = 1'b0;
    code    = '0;
    fail    = 1'b0;
    fail_st = jsu_pkg::ST_BYTE;

    if (end_i) begin
      if (!err_q) begin
        burst_o.count = 3'd1;
        unique case (phase_q)
          jsu_pkg::PH_TEXT: burst_o.status = jsu_pkg::ST_DONE;
          jsu_pkg::PH_ESC:  burst_o.status = jsu_pkg::ST_UNTERM;
          jsu_pkg::PH_HEX1: burst_o.status = jsu_pkg::ST_SHORT_U;
          default:          burst_o.status = jsu_pkg::ST_MISS_LOW;
        endcase
      end
      phase_d = jsu_pkg::PH_TEXT;
      accum_d = '0;
      count_d = '0;
      high_d  = '0;
      err_d   = 1'b0;
    end else if (!err_q) begin
      unique case (phase_q)
        jsu_pkg::PH_TEXT: begin
          if (byte_i < jsu_pkg::CH_SPACE) begin
            fail    = 1'b1;
            fail_st = jsu_pkg::ST_CTRL;
          end else if (byte_i == jsu_pkg::CH_BSL) begin
            phase_d = jsu_pkg::PH_ESC;
          end else begin
            burst_o.count    = 3'd1;
            burst_o.bytes[0] = byte_i;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (esc[8]) begin
            phase_d          = jsu_pkg::PH_TEXT;
            burst_o.count    = 3'd1;
            burst_o.bytes[0] = esc[7:0];
          end else if (byte_i == jsu_pkg::CH_U) begin
            phase_d = jsu_pkg::PH_HEX1;
            accum_d = '0;
            count_d = '0;
          end else begin
            fail    = 1'b1;
            fail_st = jsu_pkg::ST_BAD_ESC;
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
          if (!hex[4]) begin
            fail    = 1'b1;
            fail_st = jsu_pkg::ST_BAD_HEX;
          end else if (count_q != 2'd3) begin
            accum_d = hex_word[11:0];
            count_d = count_q + 2'd1;
          end else begin
            accum_d = '0;
            count_d = '0;
            if (phase_q == jsu_pkg::PH_HEX1) begin
              if (hex_word[15:10] == jsu_pkg::SUR_HIGH) begin
                high_d  = hex_word[9:0];
                phase_d = jsu_pkg::PH_BSL;
              end else if (hex_word[15:10] == jsu_pkg::SUR_LOW) begin
                fail    = 1'b1;
                fail_st = jsu_pkg::ST_LONE_LOW;
              end else begin
                phase_d = jsu_pkg::PH_TEXT;
                emit    = 1'b1;
                code    = {5'd0, hex_word};
              end
            end else if (hex_word[15:10] != jsu_pkg::SUR_LOW) begin
              fail    = 1'b1;
              fail_st = jsu_pkg::ST_BAD_LOW;
            end else begin
              phase_d = jsu_pkg::PH_TEXT;
              emit    = 1'b1;
              code    = pair_code;
            end
          end
        end
        jsu_pkg::PH_BSL: begin
          if (byte_i != jsu_pkg::CH_BSL) begin
            fail    = 1'b1;
            fail_st = jsu_pkg::ST_EXP_U;
          end else begin
            phase_d = jsu_pkg::PH_U;
          end
        end
        jsu_pkg::PH_U: begin
          if (byte_i != jsu_pkg::CH_U) begin
            fail    = 1'b1;
            fail_st = jsu_pkg::ST_EXP_U;
          end else begin
            phase_d = jsu_pkg::PH_HEX2;
            accum_d = '0;
            count_d = '0;
          end
        end
        default: begin
          phase_d = jsu_pkg::PH_TEXT;
          accum_d = '0;
          count_d = '0;
          high_d  = '0;
          err_d   = 1'b0;
        end
      endcase
    end

    if (fail) begin
      err_d          = 1'b1;
      phase_d        = jsu_pkg::PH_TEXT;
      accum_d        = '0;
      count_d        = '0;
      burst_o.count  = 3'd1;
      burst_o.status = fail_st;
    end

    // UTF-8 encode, lead byte first
    if (emit) begin
      priority if (code < 21'h80) begin
        burst_o.count    = 3'd1;
        burst_o.bytes[0] = code[7:0];
      end else if (code < 21'h800) begin
        burst_o.count    = 3'd2;
        burst_o.bytes[0] = {3'b110, code[10:6]};
        burst_o.bytes[1] = {2'b10, code[5:0]};
      end else if (code < jsu_pkg::SUPP_BASE) begin
        burst_o.count    = 3'd3;
        burst_o.bytes[0] = {4'b1110, code[15:12]};
        burst_o.bytes[1] = {2'b10, code[11:6]};
        burst_o.bytes[2] = {2'b10, code[5:0]};
      end else begin
        burst_o.count    = 3'd4;
        burst_o.bytes[0] = {5'b11110, code[20:18]};
        burst_o.bytes[1] = {2'b10, code[17:12]};
        burst_o.bytes[2] = {2'b10, code[11:6]};
        burst_o.bytes[3] = {2'b10, code[5:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_TEXT;
      accum_q <= '0;
      count_q <= '0;
      high_q  <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      count_q <= count_d;
      high_q  <= high_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ hw/rtl/jsu_burst.sv @@
// Result register: holds one burst and hands its bytes out one item at a time.
module jsu_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jsu_pkg::burst_t burst_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic [3:0]      status_o
);

  logic             valid_q;
  logic [3:0][7:0]  bytes_q;
  jsu_pkg::status_e status_q;
  logic [1:0]       last_idx_q;
  logic [1:0]       idx_q;
  logic [2:0]       last_idx_full;
  logic             at_last;
  logic             out_fire;

  assign at_last       = (idx_q == last_idx_q);
  assign out_fire      = valid_q && out_ready_i;
  assign free_o        = !valid_q || (out_ready_i && at_last);
  assign last_idx_full = burst_i.count - 3'd1;

  assign out_valid_o = valid_q;
  assign out_byte_o  = bytes_q[idx_q];
  assign run_last_o  = at_last;
  assign status_o    = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
    end else if (load_i) begin
      valid_q    <= 1'b1;
      idx_q      <= '0;
      last_idx_q <= last_idx_full[1:0];
    end else if (out_fire) begin
      // drop the burst after its last byte, else advance
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= burst_i.bytes;
      status_q <= burst_i.status;
    end
  end

endmodule

@@ hw/rtl/json_string_unescape_utf8.sv @@
// JSON string unescaper to UTF-8: input register, decoder and result register.
// Latency: an item lands in the input register at its accepting edge; its first result is
// offered from the next edge on, later only while the result register still holds a burst.
// Throughput: one item per cycle while the result register can take its burst; the result
// register hands a burst of n results out one byte per cycle while out_ready_i is high.
// Reset: asynchronous, active low; parse state returns to text, no item is held.
`include "assert_macros.svh"
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic [3:0] status_o
);

  logic            inq_valid_q;
  logic [7:0]      inq_byte_q;
  logic            inq_end_q;
  jsu_pkg::burst_t burst;
  logic            burst_free;
  logic            consume;
  logic            load;

  // an item with no result never waits for the result register
  assign consume    = inq_valid_q && ((burst.count == 3'd0) || burst_free);
  assign load       = consume && (burst.count != 3'd0);
  assign in_ready_o = !inq_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      inq_byte_q <= in_byte_i;
      inq_end_q  <= is_end_i;
    end
  end

  jsu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (consume),
    .byte_i  (inq_byte_q),
    .end_i   (inq_end_q),
    .burst_o (burst)
  );

  jsu_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (burst_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .status_o    (status_o)
  );

  `ASSERT_IMPLY(a_load_free, load, burst_free, "burst loaded over a pending result")
  `ASSERT_IMPLY(a_stall_held, !in_ready_o, inq_valid_q, "input stalled with empty register")
  `ASSERT_IMPLY(a_err_single, out_valid_o && (status_o != jsu_pkg::ST_BYTE),
                run_last_o && (out_byte_o == 8'd0), "status result not a lone zero item")
  `ASSERT_ALWAYS(a_burst_len, burst.count <= 3'd4, "burst longer than four bytes")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the JSON string unescaper with a predictor of its UTF-8 results.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_DIRECTED  = 31;
  localparam int RANDOM_ITEMS  = 210;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    jsu_pkg::status_e status;
  } result_t;

  typedef struct packed {
    logic [7:0]       chr;
    logic             fin;
    logic             typed;
    logic [7:0]       want_data;
    jsu_pkg::status_e want_status;
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_e;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       is_end_i    = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic [3:0] status_o;

  json_string_unescape_utf8 i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .is_end_i   (is_end_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o),
    .status_o   (status_o)
  );

  // Decoder state of the predictor
  jsu_pkg::phase_e dec_phase = jsu_pkg::PH_TEXT;
  logic [15:0]     dec_acc   = '0;
  int              dec_cnt   = 0;
  logic [9:0]      dec_high  = '0;
  bit              dec_err   = 1'b0;

  result_t item_res[$];
  result_t decoded_q[$];
  result_t head_res;

  int       burst_left   = 0;
  int       total_items  = 0;
  int       live_items   = 0;
  int       n_results    = 0;
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;
  rx_mode_e stall_mode   = RX_OPEN;
  bit       seen_status [16];

  logic [7:0] esc_letters [8] = '{
    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
    jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T
  };

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h20,             1'b0, 1'b1, 8'h20,             jsu_pkg::ST_BYTE},
    '{8'hFF,             1'b0, 1'b1, 8'hFF,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_QUOTE, 1'b0, 1'b1, jsu_pkg::CH_QUOTE, jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_BSL,   1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_N,     1'b0, 1'b1, jsu_pkg::CTL_LF,   jsu_pkg::ST_BYTE},
    '{8'h00,             1'b1, 1'b1, 8'h00,             jsu_pkg::ST_DONE},
    '{8'h1F,             1'b0, 1'b1, 8'h00,             jsu_pkg::ST_CTRL},
    '{8'h41,             1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'hA5,             1'b1, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_BSL,   1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'h5A,             1'b1, 1'b1, 8'h00,             jsu_pkg::ST_UNTERM},
    '{jsu_pkg::CH_BSL,   1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'h00,             1'b0, 1'b1, 8'h00,             jsu_pkg::ST_BAD_ESC},
    '{8'h00,             1'b1, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_BSL,   1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_U,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_0,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_0,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'h65,             1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_9,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_BSL,   1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_U,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'h44,             1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_B,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_UF,    1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_LF,    1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'hFF,             1'b1, 1'b1, 8'h00,             jsu_pkg::ST_MISS_LOW},
    '{jsu_pkg::CH_BSL,   1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{jsu_pkg::CH_U,     1'b0, 1'b0, 8'h00,             jsu_pkg::ST_BYTE},
    '{8'h67,             1'b0, 1'b1, 8'h00,             jsu_pkg::ST_BAD_HEX},
    '{8'h00,             1'b1, 1'b0, 8'h00,             jsu_pkg::ST_BYTE}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_decoder();
    dec_phase = jsu_pkg::PH_TEXT;
    dec_acc   = '0;
    dec_cnt   = 0;
    dec_high  = '0;
    dec_err   = 1'b0;
  endfunction

  function automatic void emit(logic [7:0] d, jsu_pkg::status_e s);
    result_t r;
    r = '{data: d, last: 1'b0, status: s};
    item_res = {item_res, r};
  endfunction

  // Report an error and drop the rest of the string
  function automatic void raise(jsu_pkg::status_e s);
    dec_err   = 1'b1;
    dec_phase = jsu_pkg::PH_TEXT;
    dec_acc   = '0;
    dec_cnt   = 0;
    emit(8'h00, s);
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], jsu_pkg::ST_BYTE);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, jsu_pkg::ST_BYTE);
      emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]}, jsu_pkg::ST_BYTE);
      emit({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
      emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
    end else begin
      emit({5'b11110, cp[20:18]}, jsu_pkg::ST_BYTE);
      emit({2'b10, cp[17:12]}, jsu_pkg::ST_BYTE);
      emit({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
      emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
    end
  endfunction

  function automatic int nibble_of(logic [7:0] b);
    if (b >= jsu_pkg::CH_0 && b <= jsu_pkg::CH_9) return int'(b - jsu_pkg::CH_0);
    if (b >= jsu_pkg::CH_LA && b <= jsu_pkg::CH_LF) return int'(b - jsu_pkg::CH_LA) + 10;
    if (b >= jsu_pkg::CH_UA && b <= jsu_pkg::CH_UF) return int'(b - jsu_pkg::CH_UA) + 10;
    return -1;
  endfunction

  function automatic int unescaped(logic [7:0] b);
    case (b)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: return int'(b);
      jsu_pkg::CH_B: return int'(jsu_pkg::CTL_BS);
      jsu_pkg::CH_F: return int'(jsu_pkg::CTL_FF);
      jsu_pkg::CH_N: return int'(jsu_pkg::CTL_LF);
      jsu_pkg::CH_R: return int'(jsu_pkg::CTL_CR);
      jsu_pkg::CH_T: return int'(jsu_pkg::CTL_HT);
      default:       return -1;
    endcase
  endfunction

  // Work out the results of one item into item_res
  function automatic void decode_item(logic [7:0] b, logic fin);
    int          esc;
    int          nib;
    logic [15:0] word;
    item_res.delete();
    if (fin) begin
      if (!dec_err) begin
        case (dec_phase)
          jsu_pkg::PH_TEXT: emit(8'h00, jsu_pkg::ST_DONE);
          jsu_pkg::PH_ESC:  emit(8'h00, jsu_pkg::ST_UNTERM);
          jsu_pkg::PH_HEX1: emit(8'h00, jsu_pkg::ST_SHORT_U);
          default:          emit(8'h00, jsu_pkg::ST_MISS_LOW);
        endcase
      end
      reset_decoder();
    end else if (!dec_err) begin
      case (dec_phase)
        jsu_pkg::PH_TEXT: begin
          if (b < jsu_pkg::CH_SPACE) raise(jsu_pkg::ST_CTRL);
          else if (b == jsu_pkg::CH_BSL) dec_phase = jsu_pkg::PH_ESC;
          else emit(b, jsu_pkg::ST_BYTE);
        end
        jsu_pkg::PH_ESC: begin
          esc = unescaped(b);
          if (esc >= 0) begin
            dec_phase = jsu_pkg::PH_TEXT;
            emit(esc[7:0], jsu_pkg::ST_BYTE);
          end else if (b == jsu_pkg::CH_U) begin
            dec_phase = jsu_pkg::PH_HEX1;
            dec_acc   = '0;
            dec_cnt   = 0;
          end else begin
            raise(jsu_pkg::ST_BAD_ESC);
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
          nib = nibble_of(b);
          if (nib < 0) begin
            raise(jsu_pkg::ST_BAD_HEX);
          end else begin
            word = {dec_acc[11:0], nib[3:0]};
            if (dec_cnt < 3) begin
              dec_acc = word;
              dec_cnt++;
            end else begin
              dec_acc = '0;
              dec_cnt = 0;
              if (dec_phase == jsu_pkg::PH_HEX1) begin
                if (word[15:10] == jsu_pkg::SUR_HIGH) begin
                  dec_high  = word[9:0];
                  dec_phase = jsu_pkg::PH_BSL;
                end else if (word[15:10] == jsu_pkg::SUR_LOW) begin
                  raise(jsu_pkg::ST_LONE_LOW);
                end else begin
                  dec_phase = jsu_pkg::PH_TEXT;
                  emit_utf8({5'd0, word});
                end
              end else if (word[15:10] != jsu_pkg::SUR_LOW) begin
                raise(jsu_pkg::ST_BAD_LOW);
              end else begin
                dec_phase = jsu_pkg::PH_TEXT;
                emit_utf8(jsu_pkg::SUPP_BASE + {1'b0, dec_high, word[9:0]});
              end
            end
          end
        end
        jsu_pkg::PH_BSL: begin
          if (b != jsu_pkg::CH_BSL) raise(jsu_pkg::ST_EXP_U);
          else dec_phase = jsu_pkg::PH_U;
        end
        jsu_pkg::PH_U: begin
          if (b != jsu_pkg::CH_U) begin
            raise(jsu_pkg::ST_EXP_U);
          end else begin
            dec_phase = jsu_pkg::PH_HEX2;
            dec_acc   = '0;
            dec_cnt   = 0;
          end
        end
        default: reset_decoder();
      endcase
    end
    if (item_res.size() > 0) item_res[item_res.size() - 1].last = 1'b1;
  endfunction

  // Offer one item in bursts with random gaps; return once it is accepted
  task automatic push_item(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [7:0] want_data, input jsu_pkg::status_e want_status);
    int      gap;
    result_t typed_res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    total_items++;
    if (!dec_err) live_items++;
    decode_item(b, fin);
    if (typed) begin
      typed_res = '{data: want_data, last: 1'b1, status: want_status};
      decoded_q = {decoded_q, typed_res};
    end else begin
      foreach (item_res[i]) decoded_q = {decoded_q, item_res[i]};
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_end_i   <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    push_item(b, fin, 1'b0, 8'h00, jsu_pkg::ST_BYTE);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return jsu_pkg::CH_0 + 8'(n);
    return (($urandom_range(0, 1) == 1) ? jsu_pkg::CH_LA : jsu_pkg::CH_UA) + 8'(n) - 8'd10;
  endfunction

  // Send the top k hex digits of w
  task automatic send_hex(input logic [15:0] w, input int k);
    for (int i = 0; i < k; i++) send_byte(hex_char(w[15 - 4 * i -: 4]), 1'b0);
  endtask

  task automatic send_unicode(input logic [15:0] w, input int k);
    send_byte(jsu_pkg::CH_BSL, 1'b0);
    send_byte(jsu_pkg::CH_U, 1'b0);
    send_hex(w, k);
  endtask

  // Hold off the sender until every predicted result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  // One string: mostly well-formed tokens, sometimes an error or a cut, then the end marker
  task automatic gen_string();
    int          tokens;
    int          pick;
    int          k;
    logic [7:0]  b;
    logic [15:0] w;
    logic [15:0] hi;
    bit          ok;
    bit          cut;
    tokens = $urandom_range(0, 8);
    cut = 1'b0;
    for (int t = 0; t < tokens && !cut; t++) begin
      pick = $urandom_range(0, 99);
      hi = {jsu_pkg::SUR_HIGH, 10'($urandom)};
      if (pick < 40) begin
        do b = 8'($urandom_range(32, 255)); while (b == jsu_pkg::CH_BSL);
        send_byte(b, 1'b0);
      end else if (pick < 55) begin
        send_byte(jsu_pkg::CH_BSL, 1'b0);
        send_byte(esc_letters[$urandom_range(0, 7)], 1'b0);
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       w = 16'($urandom_range(16'h0000, 16'h007F));
          1:       w = 16'($urandom_range(16'h0080, 16'h07FF));
          2:       w = 16'($urandom_range(16'h0800, 16'hD7FF));
          default: w = 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
        send_unicode(w, 4);
      end else if (pick < 90) begin
        send_unicode(hi, 4);
        send_unicode({jsu_pkg::SUR_LOW, 10'($urandom)}, 4);
      end else begin
        cut = 1'b1;
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0: send_byte(8'($urandom_range(0, 31)), 1'b0);
          1: begin
            send_byte(jsu_pkg::CH_BSL, 1'b0);
            do begin
              b = 8'($urandom_range(0, 255));
              ok = (b != jsu_pkg::CH_U);
              foreach (esc_letters[i]) if (esc_letters[i] == b) ok = 1'b0;
            end while (!ok);
            send_byte(b, 1'b0);
          end
          2: begin
            // bad digit in either group
            if ($urandom_range(0, 1) == 1) begin
              send_unicode(hi, 4);
              send_byte(jsu_pkg::CH_BSL, 1'b0);
              send_byte(jsu_pkg::CH_U, 1'b0);
            end else begin
              send_byte(jsu_pkg::CH_BSL, 1'b0);
              send_byte(jsu_pkg::CH_U, 1'b0);
            end
            send_hex(16'($urandom), k);
            do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
            send_byte(b, 1'b0);
          end
          3: send_unicode({jsu_pkg::SUR_LOW, 10'($urandom)}, 4);
          4: begin
            send_unicode(hi, 4);
            do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_BSL);
            send_byte(b, 1'b0);
          end
          5: begin
            send_unicode(hi, 4);
            send_byte(jsu_pkg::CH_BSL, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_U);
            send_byte(b, 1'b0);
          end
          6: begin
            send_unicode(hi, 4);
            do w = 16'($urandom); while (w[15:10] == jsu_pkg::SUR_LOW);
            send_unicode(w, 4);
          end
          7: send_byte(jsu_pkg::CH_BSL, 1'b0);
          8: send_unicode(16'($urandom), k);
          default: begin
            // cut somewhere after a high surrogate
            send_unicode(hi, 4);
            k = $urandom_range(0, 2);
            if (k >= 1) send_byte(jsu_pkg::CH_BSL, 1'b0);
            if (k == 2) begin
              send_byte(jsu_pkg::CH_U, 1'b0);
              send_hex(16'($urandom), $urandom_range(0, 3));
            end
          end
        endcase
      end
    end
    if (dec_err) repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatch_cnt++;
    $display("tb: result %0d %s: got 0x%0h, want 0x%0h", n_results, what, got, want);
  endtask

  // Receiver: drives out_ready_i in the stall pattern of a randomly chosen mode
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt % 97 == 0) stall_mode = rx_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= (cycle_cnt % 5 != 2);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (decoded_q.size() == 0) begin
        flag_mismatch("with no prediction pending", out_byte_o, 8'h00);
      end else begin
        head_res = decoded_q.pop_front();
        if (out_byte_o !== head_res.data) flag_mismatch("out_byte", out_byte_o, head_res.data);
        if (run_last_o !== head_res.last) begin
          flag_mismatch("run_last", 8'(run_last_o), 8'(head_res.last));
        end
        if (status_o !== head_res.status) begin
          flag_mismatch("status", 8'(status_o), 8'(head_res.status));
        end
        seen_status[head_res.status] = 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("tb: timeout after %0d cycles, %0d results pending", cycle_cnt, decoded_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n_codes;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].chr, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].want_data, directed_rows[i].want_status);
    end
    drain_results();

    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      gen_string();
      if ($urandom_range(0, 11) == 0) drain_results();
    end
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    n_codes = 0;
    foreach (seen_status[i]) if (seen_status[i]) n_codes++;
    $display("tb: %0d items sent (%0d directed), %0d results checked in %0d cycles",
             total_items, NUM_DIRECTED, n_results, cycle_cnt);
    $display("tb: %0d of 11 status codes observed, %0d mismatches", n_codes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ json_string_unescape_utf8.f @@
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_burst.sv
hw/rtl/json_string_unescape_utf8.sv
sim/tb.sv
